// File: rtl/cvr_pkg.sv
// Shared types, constants and the arctangent table for the CORDIC vector rotator.
// Has no dependencies; the other files refer to it by scoped names or import it.
package cvr_pkg;

    localparam int DATA_W         = 32;
    localparam int ANGLE_W        = 31;
    localparam int ITERATIONS_DEF = 30;
    localparam int ITERATIONS_MAX = 30;
    localparam int ATAN_IDX_W     = 5;
    localparam int GAIN_SHIFT     = 30;

    typedef logic [DATA_W-1:0]         word_t;
    typedef logic signed [DATA_W-1:0]  sword_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // pi and pi/2 in signed 4.28, gain 0.27157 in 2.30.
    localparam word_t  PI_ANGLE      = 32'd843314857;
    localparam sword_t HALF_PI_ANGLE = 32'sd421657428;
    localparam sword_t GAIN          = 32'sd291597965;

    // Working vector carried between the sequencer and the shift-add unit.
    typedef struct packed {
        word_t x;
        word_t y;
        word_t a;
    } vec_t;

    // Entry 0 is atan(2), entry n is atan(2^-(n-1)), all in 4.28 radians.
    function automatic word_t atan_at(logic [ATAN_IDX_W-1:0] idx);
        word_t val;
        unique case (idx)
            5'd0:    val = 32'd297197971;
            5'd1:    val = 32'd210828714;
            5'd2:    val = 32'd124459457;
            5'd3:    val = 32'd65760959;
            5'd4:    val = 32'd33381290;
            5'd5:    val = 32'd16755422;
            5'd6:    val = 32'd8385879;
            5'd7:    val = 32'd4193963;
            5'd8:    val = 32'd2097109;
            5'd9:    val = 32'd1048571;
            5'd10:   val = 32'd524287;
            5'd11:   val = 32'd262144;
            5'd12:   val = 32'd131072;
            5'd13:   val = 32'd65536;
            5'd14:   val = 32'd32768;
            5'd15:   val = 32'd16384;
            5'd16:   val = 32'd8192;
            5'd17:   val = 32'd4096;
            5'd18:   val = 32'd2048;
            5'd19:   val = 32'd1024;
            5'd20:   val = 32'd512;
            5'd21:   val = 32'd256;
            5'd22:   val = 32'd128;
            5'd23:   val = 32'd64;
            5'd24:   val = 32'd32;
            5'd25:   val = 32'd16;
            5'd26:   val = 32'd8;
            5'd27:   val = 32'd4;
            5'd28:   val = 32'd2;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/cvr_in_if.sv
// Input channel of the CORDIC vector rotator: valid/ready handshake with the
// vector and the angle. Depends on cvr_pkg.
interface cvr_in_if;
    logic                 valid;
    logic                 ready;
    cvr_pkg::sword_t      x_in;
    cvr_pkg::sword_t      y_in;
    cvr_pkg::angle_t      angle;

    modport source (output valid, output x_in, output y_in, output angle, input ready);
    modport sink   (input valid, input x_in, input y_in, input angle, output ready);
endinterface

// File: rtl/cvr_out_if.sv
// Output channel of the CORDIC vector rotator: valid/ready handshake with the
// rotated vector. Depends on cvr_pkg.
interface cvr_out_if;
    logic                 valid;
    logic                 ready;
    cvr_pkg::sword_t      x_out;
    cvr_pkg::sword_t      y_out;

    modport source (output valid, output x_out, output y_out, input ready);
    modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

// File: rtl/cvr_step.sv
// Shared CORDIC shift-add unit: one micro-rotation per use, combinational.
// Depends on cvr_pkg for the vector type and the arctangent table.
module cvr_step #(
    parameter int ITERATIONS = cvr_pkg::ITERATIONS_DEF,
    localparam int STEP_W    = $clog2(ITERATIONS + 1)
) (
    input  cvr_pkg::vec_t      vec,
    input  logic [STEP_W-1:0]  step,
    output cvr_pkg::vec_t      result
);

    logic [STEP_W-1:0] shift;
    cvr_pkg::word_t    xs;
    cvr_pkg::word_t    ys;
    cvr_pkg::word_t    atan_val;
    logic              rot_neg;

    // Step zero doubles (atan(2)); step k shifts right by k-1.
    always_comb
    begin
        shift    = step - STEP_W'(1);
        atan_val = cvr_pkg::atan_at(cvr_pkg::ATAN_IDX_W'(step));
        rot_neg  = vec.a[cvr_pkg::DATA_W-1];
        if (step == '0)
        begin
            xs = vec.x << 1;
            ys = vec.y << 1;
        end
        else
        begin
            xs = cvr_pkg::word_t'($signed(vec.x) >>> shift);
            ys = cvr_pkg::word_t'($signed(vec.y) >>> shift);
        end
        if (rot_neg)
        begin
            result.x = vec.x + ys;
            result.y = vec.y - xs;
            result.a = vec.a + atan_val;
        end
        else
        begin
            result.x = vec.x - ys;
            result.y = vec.y + xs;
            result.a = vec.a - atan_val;
        end
    end

endmodule

// File: rtl/cvr_gain.sv
// Gain compensation multiplier: registered signed product with the CORDIC gain,
// read back as the product shifted right by 30. Depends on cvr_pkg.
module cvr_gain (
    input  logic            clk,
    input  cvr_pkg::word_t  operand,
    output cvr_pkg::word_t  scaled
);

    logic signed [2*cvr_pkg::DATA_W-1:0] product_reg;
    logic signed [2*cvr_pkg::DATA_W-1:0] product_next;

    always_comb
    begin
        product_next = $signed(operand) * cvr_pkg::GAIN;
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign scaled = product_reg[cvr_pkg::GAIN_SHIFT +: cvr_pkg::DATA_W];

endmodule

// File: rtl/cordic_vector_rotate.sv
// Rotates a signed 16.16 vector (x_in, y_in) by a signed 4.28 radian angle
// with rotation-mode CORDIC and returns the gain-compensated result.
// Depends on cvr_pkg, cvr_in_if, cvr_out_if, cvr_step and cvr_gain.
//
// The block handles one item at a time. After an item is accepted, the fold
// state brings the angle into the range minus pi/2 to pi/2 (angles beyond it
// are reflected and the x result is negated at the end), then the single
// shared shift-add unit runs ITERATIONS + 1 micro-rotations, one per cycle:
// first a doubling step with atan(2), then shifts by 0 through ITERATIONS - 1.
// A single registered 32 by 32 multiplier then scales x and y by the gain in
// turn, through the states SCALE_X, SCALE_Y and SCALE_END. The result is
// presented from registers and held until taken; the block returns to
// accepting in the cycle after the result is taken. Sums wrap in 32 bits and
// right shifts are arithmetic throughout.
module cordic_vector_rotate #(
    parameter int ITERATIONS = cvr_pkg::ITERATIONS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cvr_in_if.sink    in_chan,
    cvr_out_if.source out_chan
);

    localparam int STEP_W = $clog2(ITERATIONS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITERATIONS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ROTATE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_SCALE_END,
        ST_OUT
    } state_t;

    state_t             state_reg,  state_next;
    cvr_pkg::vec_t      vec_reg,    vec_next;
    logic [STEP_W-1:0]  step_reg,   step_next;
    logic               flip_reg,   flip_next;
    cvr_pkg::word_t     x_res_reg,  x_res_next;
    cvr_pkg::word_t     y_res_reg,  y_res_next;

    cvr_pkg::vec_t      step_result;
    cvr_pkg::word_t     mult_operand;
    cvr_pkg::word_t     scaled;

    cvr_step #(
        .ITERATIONS (ITERATIONS)
    ) u_step (
        .vec    (vec_reg),
        .step   (step_reg),
        .result (step_result)
    );

    // The multiplier sees x during the first scaling cycle and y after it.
    assign mult_operand = (state_reg == ST_SCALE_Y) ? vec_reg.y : vec_reg.x;

    cvr_gain u_gain (
        .clk     (clk),
        .operand (mult_operand),
        .scaled  (scaled)
    );

    always_comb
    begin
        state_next = state_reg;
        vec_next   = vec_reg;
        step_next  = step_reg;
        flip_next  = flip_reg;
        x_res_next = x_res_reg;
        y_res_next = y_res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_chan.valid)
                begin
                    vec_next.x = in_chan.x_in;
                    vec_next.y = in_chan.y_in;
                    vec_next.a = {in_chan.angle[cvr_pkg::ANGLE_W-1], in_chan.angle};
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                // Reflect angles beyond plus or minus pi/2 back into range.
                if ($signed(vec_reg.a) > cvr_pkg::HALF_PI_ANGLE)
                begin
                    vec_next.a = cvr_pkg::PI_ANGLE - vec_reg.a;
                    flip_next  = 1'b1;
                end
                else if ($signed(vec_reg.a) < -cvr_pkg::HALF_PI_ANGLE)
                begin
                    vec_next.a = '0 - (cvr_pkg::PI_ANGLE + vec_reg.a);
                    flip_next  = 1'b1;
                end
                else
                begin
                    flip_next = 1'b0;
                end
                step_next  = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                vec_next = step_result;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_SCALE_X;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SCALE_X:
            begin
                state_next = ST_SCALE_Y;
            end
            ST_SCALE_Y:
            begin
                x_res_next = scaled;
                state_next = ST_SCALE_END;
            end
            ST_SCALE_END:
            begin
                y_res_next = scaled;
                if (flip_reg)
                begin
                    x_res_next = '0 - x_res_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_chan.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vec_reg   <= '0;
            step_reg  <= '0;
            flip_reg  <= 1'b0;
            x_res_reg <= '0;
            y_res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vec_reg   <= vec_next;
            step_reg  <= step_next;
            flip_reg  <= flip_next;
            x_res_reg <= x_res_next;
            y_res_reg <= y_res_next;
        end
    end

    assign in_chan.ready  = (state_reg == ST_IDLE);
    assign out_chan.valid = (state_reg == ST_OUT);
    assign out_chan.x_out = $signed(x_res_reg);
    assign out_chan.y_out = $signed(y_res_reg);

endmodule

// File: test/cvr_rotate_checker.sv
`timescale 1ns / 1ps
// Checker for the CORDIC vector rotator: watches both channels, predicts each rotation
// and compares it with the block's result. Depends on cvr_pkg, cvr_in_if and cvr_out_if.
module cvr_rotate_checker
    import cvr_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    cvr_in_if    in_mon,
    cvr_out_if   out_mon,
    output int   fail_count,
    output int   outstanding
);

    typedef struct packed {
        sword_t x;
        sword_t y;
    } rotated_t;

    // atan(2) first, then atan(2^-i) for i = 0 upward, in 4.28 radians.
    localparam word_t ARCTAN_4_28 [0:30] = '{
        32'd297197971, 32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290,
        32'd16755422, 32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571,
        32'd524287, 32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384,
        32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128,
        32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    rotated_t pending_rotations [$];

    function automatic word_t apply_gain(word_t v);
        logic signed [63:0] prod;
        begin
            prod = {{32{v[31]}}, v};
            prod = prod * 64'sd291597965;
            prod = prod >>> GAIN_SHIFT;
            return prod[31:0];
        end
    endfunction

    function automatic rotated_t rotate_vector(sword_t x0, sword_t y0, angle_t ang);
        word_t    x;
        word_t    y;
        word_t    a;
        word_t    t;
        word_t    xs;
        word_t    ys;
        logic     flip;
        rotated_t r;
        begin
            x = x0;
            y = y0;
            a = {ang[ANGLE_W-1], ang};
            flip = 1'b0;
            if ($signed(a) > HALF_PI_ANGLE)
            begin
                a = PI_ANGLE - a;
                flip = 1'b1;
            end
            else if ($signed(a) < -HALF_PI_ANGLE)
            begin
                a = -(PI_ANGLE + a);
                flip = 1'b1;
            end
            if (a[31])
            begin
                t = x + (y << 1);
                y = y - (x << 1);
                x = t;
                a = a + ARCTAN_4_28[0];
            end
            else
            begin
                t = x - (y << 1);
                y = y + (x << 1);
                x = t;
                a = a - ARCTAN_4_28[0];
            end
            for (int i = 0; i < ITERATIONS; i++)
            begin
                xs = $signed(x) >>> i;
                ys = $signed(y) >>> i;
                if (a[31])
                begin
                    t = x + ys;
                    y = y - xs;
                    x = t;
                    a = a + ARCTAN_4_28[i + 1];
                end
                else
                begin
                    t = x - ys;
                    y = y + xs;
                    x = t;
                    a = a - ARCTAN_4_28[i + 1];
                end
            end
            x = apply_gain(x);
            y = apply_gain(y);
            if (flip)
                x = -x;
            r.x = x;
            r.y = y;
            return r;
        end
    endfunction

    always @(posedge clk)
    begin
        rotated_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            outstanding = 0;
            pending_rotations.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (pending_rotations.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result x=%h y=%h", $time,
                                 out_mon.x_out, out_mon.y_out);
                end
                else
                begin
                    want = pending_rotations.pop_front();
                    if (want.x !== out_mon.x_out || want.y !== out_mon.y_out)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("%0t: mismatch x exp %h got %h, y exp %h got %h",
                                     $time, want.x, out_mon.x_out, want.y, out_mon.y_out);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                pending_rotations.push_back(rotate_vector(in_mon.x_in, in_mon.y_in,
                                                          in_mon.angle));
            outstanding = pending_rotations.size();
        end
    end

endmodule

// File: test/cordic_vector_rotate_tb.sv
`timescale 1ns / 1ps
// Testbench top for the CORDIC vector rotator: clock, reset, stimulus and verdict.
// Depends on cvr_pkg, cvr_in_if, cvr_out_if, cordic_vector_rotate and cvr_rotate_checker.
module cordic_vector_rotate_tb;
    import cvr_pkg::*;

    // The block under test runs the full number of shift-add steps.
    localparam int ROT_STEPS = 30;

    // The run is given up after this many cycles. A correct run of roughly 870
    // items ends well before it.
    localparam int CYCLE_LIMIT = 500000;

    localparam int RANDOM_ITEMS = 850;

    // Items in this window are sent with neither side idling.
    localparam int CALM_FIRST = 300;
    localparam int CALM_LAST  = 420;

    // Before this random item the sender holds off until the block has drained.
    localparam int DRAIN_AT = 600;

    localparam int PI_I      = 843314857;
    localparam int HALF_PI_I = 421657428;
    localparam int ONE_16_16 = 65536;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   outstanding;
    int   cycle_count;

    cvr_in_if  in_chan ();
    cvr_out_if out_chan ();

    cordic_vector_rotate #(
        .ITERATIONS (ROT_STEPS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    cvr_rotate_checker #(
        .ITERATIONS (ROT_STEPS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_chan),
        .out_mon     (out_chan),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a block that stops answering ends here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // The receiver stalls at random, with a chance of 23 percent, except in the calm
    // window. Ready changes on the falling edge like every other input.
    initial
    begin
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_chan.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
        end
    end

    // Offers one item and returns on the falling edge after it was taken. The
    // sender may idle first, with valid low, for a random number of cycles.
    // The task is always entered on a falling edge, and valid is written at
    // most once per edge, so a back-to-back item keeps valid high throughout.
    task automatic send_item(input sword_t x, input sword_t y, input angle_t a);
        begin
            while (!calm && $urandom_range(0, 99) < 23)
            begin
                in_chan.valid <= 1'b0;
                @(negedge clk);
            end
            in_chan.valid <= 1'b1;
            in_chan.x_in  <= x;
            in_chan.y_in  <= y;
            in_chan.angle <= a;
            @(posedge clk);
            while (!in_chan.ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Coordinates come from a mix of full-range words, values of a few units,
    // values between minus one and one, and the corner words, so that both
    // overflow and the ordinary numeric range see plenty of traffic.
    function automatic sword_t pick_coord();
        int unsigned pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                return sword_t'($urandom);
            else if (pick < 6)
                return sword_t'(int'($urandom_range(0, 16 * ONE_16_16)) - 8 * ONE_16_16);
            else if (pick < 8)
                return sword_t'(int'($urandom_range(0, 2 * ONE_16_16)) - ONE_16_16);
            case ($urandom_range(0, 5))
                0:       return 32'sh7fffffff;
                1:       return 32'sh80000000;
                2:       return 32'sh0;
                3:       return -32'sd1;
                4:       return -sword_t'(ONE_16_16);
                default: return sword_t'(ONE_16_16);
            endcase
        end
    endfunction

    initial
    begin
        int     a;
        sword_t rx;
        sword_t ry;

        in_chan.valid = 1'b0;
        in_chan.x_in  = '0;
        in_chan.y_in  = '0;
        in_chan.angle = '0;
        calm  = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. The unit vector gives cos and sin of the angle
        // directly; the angles cover zero, both quarter-turn boundaries and
        // the first values past them, where the fold starts, and both ends
        // of the half turn.
        send_item(ONE_16_16, 0, 0);
        send_item(ONE_16_16, 0, angle_t'(HALF_PI_I));
        send_item(ONE_16_16, 0, angle_t'(HALF_PI_I + 1));
        send_item(ONE_16_16, 0, angle_t'(-HALF_PI_I));
        send_item(ONE_16_16, 0, angle_t'(-HALF_PI_I - 1));
        send_item(ONE_16_16, 0, angle_t'(PI_I));
        send_item(ONE_16_16, 0, angle_t'(-PI_I));
        send_item(ONE_16_16, 0, angle_t'(HALF_PI_I / 2));
        send_item(ONE_16_16, 0, angle_t'(-HALF_PI_I / 3));
        send_item(0, ONE_16_16, angle_t'(PI_I - 1));
        // Extreme coordinates: sums and the doubling step wrap in 32 bits.
        send_item(32'sh7fffffff, 32'sh7fffffff, 0);
        send_item(32'sh80000000, 32'sh80000000, 0);
        send_item(32'sh7fffffff, 32'sh80000000, angle_t'(PI_I));
        send_item(32'sh80000000, 32'sh7fffffff, angle_t'(-PI_I));
        send_item(32'sh80000000, 0, angle_t'(HALF_PI_I));
        send_item(-32'sd1, -32'sd1, angle_t'(-HALF_PI_I - 1));
        send_item(0, 0, angle_t'(PI_I));
        send_item(32'sh7fffffff, 0, angle_t'(HALF_PI_I + 1));
        send_item(32'sh55555555, 32'shaaaaaaaa, angle_t'(-PI_I + 1));
        send_item(32'shaaaaaaaa, 32'sh55555555, angle_t'(PI_I / 3));

        // Random part.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == DRAIN_AT)
            begin
                in_chan.valid <= 1'b0;
                @(negedge clk);
                while (outstanding != 0)
                    @(negedge clk);
            end
            // Three draws in eight are uniform over minus pi to pi, the rest close to the
            // fold boundaries, zero and the ends of the range.
            case ($urandom_range(0, 7))
                0:       a = HALF_PI_I + int'($urandom_range(0, 64)) - 32;
                1:       a = -HALF_PI_I + int'($urandom_range(0, 64)) - 32;
                2:       a = PI_I - int'($urandom_range(0, 64));
                3:       a = -PI_I + int'($urandom_range(0, 64));
                4:       a = int'($urandom_range(0, 64)) - 32;
                default: a = int'($urandom_range(0, 2 * PI_I)) - PI_I;
            endcase
            rx = pick_coord();
            ry = pick_coord();
            send_item(rx, ry, angle_t'(a));
        end
        calm = 1'b0;
        in_chan.valid <= 1'b0;

        // Let every result drain, then a little more so that a stray extra
        // result would still be caught by the checker.
        while (outstanding != 0)
            @(negedge clk);
        repeat (ROT_STEPS + 10) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
